### design/arrow_head_tip_generator_macros.svh
// Assertion helpers shared by the arrow head tip generator
`ifndef ARROW_HEAD_TIP_GENERATOR_MACROS_SVH
`define ARROW_HEAD_TIP_GENERATOR_MACROS_SVH

// same-cycle implication, off during reset
`define AHT_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define AHT_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, active during reset
`define AHT_CHECK_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/aht_pkg.sv
`default_nettype none
package aht_pkg;

  localparam int COORD_BITS     = 12;
  localparam int HEAD_LENGTH_DF = 30;
  localparam int FRAC_BITS_DF   = 16;

  // magnitude of the back-vector: below 2^COORD_BITS / 8
  localparam int VW = COORD_BITS - 3;
  localparam int SW = 2 * VW + 1;

  // n / 10 == (n * D10_MUL) >> D10_SHIFT for n below 2^18
  localparam logic [15:0] D10_MUL   = 16'd52429;
  localparam int          D10_SHIFT = 19;

  localparam longint COS20_Q24 = 15765426;
  localparam longint SIN20_Q24 = 5738146;
  localparam longint COS40_Q24 = 12852093;
  localparam longint SIN40_Q24 = 10784187;

  typedef struct packed {
    logic [COORD_BITS-1:0] tail_x;
    logic [COORD_BITS-1:0] tail_y;
    logic [COORD_BITS-1:0] head_x;
    logic [COORD_BITS-1:0] head_y;
  } vec_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] first_tip_x;
    logic [COORD_BITS-1:0] first_tip_y;
    logic [COORD_BITS-1:0] second_tip_x;
    logic [COORD_BITS-1:0] second_tip_y;
    logic                  degenerate;
  } tip_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  // round a 24-fraction-bit constant to f fraction bits
  function automatic longint to_frac(input longint q24, input int f);
    return (q24 * 2 + (64'sd1 <<< (24 - f))) >>> (25 - f);
  endfunction

endpackage
`default_nettype wire

### design/aht_prep.sv
`default_nettype none
module aht_prep
  import aht_pkg::*;
#(
  parameter int HEAD_LENGTH = HEAD_LENGTH_DF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire vec_t                      vec,
  output logic                           valid,
  output logic [SW-1:0]                  s,
  output logic [2*VW+2*$clog2(HEAD_LENGTH+1)-1:0] m2x,
  output logic [2*VW+2*$clog2(HEAD_LENGTH+1)-1:0] m2y,
  output logic                           negx,
  output logic                           negy,
  output point_t                         head,
  output logic                           degen
);

  localparam int LW = $clog2(HEAD_LENGTH + 1);
  localparam int MW = 2 * VW + 2 * LW;
  localparam logic [2*LW-1:0] LSQ = (2*LW)'(HEAD_LENGTH * HEAD_LENGTH);

  logic                    v1, v2, v3;
  logic [COORD_BITS-1:0]   dmx, dmy;
  logic                    dnx, dny;
  point_t                  h1, h2, h3;
  logic [VW-1:0]           vmx, vmy;
  logic                    vnx, vny, vnx3, vny3;
  logic [2*VW-1:0]         sqx, sqy;

  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS+15:0]     px, py, qx, qy;

  assign dx = $signed({1'b0, vec.head_x}) - $signed({1'b0, vec.tail_x});
  assign dy = $signed({1'b0, vec.head_y}) - $signed({1'b0, vec.tail_y});
  assign px = (COORD_BITS+16)'(dmx) * (COORD_BITS+16)'(D10_MUL);
  assign py = (COORD_BITS+16)'(dmy) * (COORD_BITS+16)'(D10_MUL);
  assign qx = px >> D10_SHIFT;
  assign qy = py >> D10_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dnx  <= dx[COORD_BITS];
      dny  <= dy[COORD_BITS];
      dmx  <= dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
      dmy  <= dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
      h1   <= '{x: vec.head_x, y: vec.head_y};
      vmx  <= qx[VW-1:0];
      vmy  <= qy[VW-1:0];
      vnx  <= !dnx;
      vny  <= !dny;
      h2   <= h1;
      sqx  <= (2*VW)'(vmx) * (2*VW)'(vmx);
      sqy  <= (2*VW)'(vmy) * (2*VW)'(vmy);
      vnx3 <= vnx;
      vny3 <= vny;
      h3   <= h2;
      s    <= SW'(sqx) + SW'(sqy);
      m2x  <= MW'(sqx) * MW'(LSQ);
      m2y  <= MW'(sqy) * MW'(LSQ);
      negx <= vnx3;
      negy <= vny3;
      degen <= (sqx == '0) && (sqy == '0);
      head <= h3;
    end
  end

endmodule
`default_nettype wire

### design/aht_scale.sv
`default_nettype none
module aht_scale
  import aht_pkg::*;
#(
  parameter int HEAD_LENGTH = HEAD_LENGTH_DF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      en,
  input  wire logic                                      in_valid,
  input  wire logic [SW-1:0]                             s,
  input  wire logic [2*VW+2*$clog2(HEAD_LENGTH+1)-1:0]   m2x,
  input  wire logic [2*VW+2*$clog2(HEAD_LENGTH+1)-1:0]   m2y,
  input  wire logic                                      negx,
  input  wire logic                                      negy,
  input  wire point_t                                    head_in,
  input  wire logic                                      degen_in,
  output logic                                           valid,
  output logic signed [$clog2(HEAD_LENGTH+1)+1:0]        wx,
  output logic signed [$clog2(HEAD_LENGTH+1)+1:0]        wy,
  output point_t                                         head,
  output logic                                           degen
);

  localparam int LW = $clog2(HEAD_LENGTH + 1);
  localparam int MW = 2 * VW + 2 * LW;
  localparam int PW = SW + 2 * LW;
  localparam int WW = LW + 2;

  logic [LW-1:0] rs [2][1:LW];
  logic [PW-1:0] ps [2][1:LW];
  logic [MW-1:0] ms [2][1:LW];
  logic          ng [2][1:LW];
  logic [SW-1:0] ss [1:LW];
  point_t        hs [1:LW];
  logic          dg [1:LW];
  logic          vs [1:LW];
  logic signed [WW-1:0] wl [2];

  for (genvar k = 0; k < LW; k++) begin : g_step
    logic [SW-1:0] s_cur;
    point_t        h_cur;
    logic          d_cur;
    logic          v_cur;

    if (k == 0) begin : g_first
      assign s_cur = s;
      assign h_cur = head_in;
      assign d_cur = degen_in;
      assign v_cur = in_valid;
    end else begin : g_next
      assign s_cur = ss[k];
      assign h_cur = hs[k];
      assign d_cur = dg[k];
      assign v_cur = vs[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k+1] <= 1'b0;
      end else if (en) begin
        vs[k+1] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ss[k+1] <= s_cur;
        hs[k+1] <= h_cur;
        dg[k+1] <= d_cur;
      end
    end

    for (genvar g = 0; g < 2; g++) begin : g_lane
      logic [LW-1:0] r_cur;
      logic [PW-1:0] p_cur;
      logic [MW-1:0] m_cur;
      logic          n_cur;
      logic [LW-1:0] t;
      logic [LW:0]   inc;
      logic [PW-1:0] pt;
      logic          ok;

      if (k == 0) begin : g_first
        assign r_cur = '0;
        assign p_cur = '0;
        assign m_cur = (g == 0) ? m2x : m2y;
        assign n_cur = (g == 0) ? negx : negy;
      end else begin : g_next
        assign r_cur = rs[g][k];
        assign p_cur = ps[g][k];
        assign m_cur = ms[g][k];
        assign n_cur = ng[g][k];
      end

      // (r + b)^2 s = r^2 s + s (2r + b) b, with b = 2^j
      always_comb begin
        t   = r_cur | (LW'(1) << (LW - 1 - k));
        inc = {r_cur, 1'b0} + ((LW+1)'(1) << (LW - 1 - k));
        pt  = p_cur + ((PW'(s_cur) * PW'(inc)) << (LW - 1 - k));
        ok  = pt <= PW'(m_cur);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rs[g][k+1] <= ok ? t : r_cur;
          ps[g][k+1] <= ok ? pt : p_cur;
          ms[g][k+1] <= m_cur;
          ng[g][k+1] <= n_cur;
        end
      end
    end
  end

  // floor for a negative component: round the magnitude up unless exact
  for (genvar g = 0; g < 2; g++) begin : g_fin
    always_comb begin
      if (!ng[g][LW]) begin
        wl[g] = WW'(rs[g][LW]);
      end else if (ps[g][LW] == PW'(ms[g][LW])) begin
        wl[g] = -WW'(rs[g][LW]);
      end else begin
        wl[g] = -(WW'(rs[g][LW]) + WW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= vs[LW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx    <= wl[0];
      wy    <= wl[1];
      head  <= hs[LW];
      degen <= dg[LW];
    end
  end

endmodule
`default_nettype wire

### design/aht_rot.sv
`default_nettype none
module aht_rot
  import aht_pkg::*;
#(
  parameter int HEAD_LENGTH = HEAD_LENGTH_DF,
  parameter int FRAC_BITS   = FRAC_BITS_DF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic signed [$clog2(HEAD_LENGTH+1)+1:0] wx,
  input  wire logic signed [$clog2(HEAD_LENGTH+1)+1:0] wy,
  input  wire point_t                             head_in,
  input  wire logic                               degen_in,
  output logic                                    valid,
  output tip_t                                    tip
);

  localparam int LW   = $clog2(HEAD_LENGTH + 1);
  localparam int WW   = LW + 2;
  localparam int RW   = LW + 3;
  localparam int KW   = FRAC_BITS + 2;
  localparam int TW   = RW + KW + 1;
  localparam int SUMW = COORD_BITS + 2;
  localparam logic signed [KW-1:0] C20 = KW'(to_frac(COS20_Q24, FRAC_BITS));
  localparam logic signed [KW-1:0] S20 = KW'(to_frac(SIN20_Q24, FRAC_BITS));
  localparam logic signed [KW-1:0] C40 = KW'(to_frac(COS40_Q24, FRAC_BITS));
  localparam logic signed [KW-1:0] S40 = KW'(to_frac(SIN40_Q24, FRAC_BITS));
  localparam logic [COORD_BITS-1:0] CMAX = '1;

  function automatic logic signed [RW-1:0] trunc_frac(input logic signed [TW-1:0] p);
    logic [TW-1:0] mag;
    logic [TW-1:0] q;
    mag = p[TW-1] ? TW'(-p) : TW'(p);
    q   = mag >> FRAC_BITS;
    return p[TW-1] ? -$signed(q[RW-1:0]) : $signed(q[RW-1:0]);
  endfunction

  function automatic logic [COORD_BITS-1:0] sat(input logic [COORD_BITS-1:0] h,
                                                input logic signed [RW-1:0] r);
    logic signed [SUMW-1:0] sum;
    sum = $signed({2'b00, h}) + SUMW'(r);
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed({2'b00, CMAX})) begin
      return CMAX;
    end else begin
      return sum[COORD_BITS-1:0];
    end
  endfunction

  logic                  va, vb, vc, vd;
  point_t                ha, hb, hc, hd;
  logic                  da, db, dc, dd;
  logic signed [TW-1:0]  pa0, pa1, pa2, pa3;
  logic signed [RW-1:0]  r1x, r1y, r1xc, r1yc, r1xd, r1yd, r2x, r2y;
  logic signed [TW-1:0]  pc0, pc1, pc2, pc3;

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      vc    <= 1'b0;
      vd    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      va    <= in_valid;
      vb    <= va;
      vc    <= vb;
      vd    <= vc;
      valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa0  <= TW'(wx) * TW'(C20);
      pa1  <= TW'(wy) * TW'(S20);
      pa2  <= TW'(wx) * TW'(S20);
      pa3  <= TW'(wy) * TW'(C20);
      ha   <= head_in;
      da   <= degen_in;
      r1x  <= trunc_frac(pa0 - pa1);
      r1y  <= trunc_frac(pa2 + pa3);
      hb   <= ha;
      db   <= da;
      pc0  <= TW'(r1x) * TW'(C40);
      pc1  <= TW'(r1y) * TW'(S40);
      pc2  <= TW'(r1y) * TW'(C40);
      pc3  <= TW'(r1x) * TW'(S40);
      r1xc <= r1x;
      r1yc <= r1y;
      hc   <= hb;
      dc   <= db;
      r2x  <= trunc_frac(pc0 + pc1);
      r2y  <= trunc_frac(pc2 - pc3);
      r1xd <= r1xc;
      r1yd <= r1yc;
      hd   <= hc;
      dd   <= dc;
      if (dd) begin
        tip <= '{first_tip_x: hd.x, first_tip_y: hd.y,
                 second_tip_x: hd.x, second_tip_y: hd.y, degenerate: 1'b1};
      end else begin
        tip <= '{first_tip_x: sat(hd.x, r1xd), first_tip_y: sat(hd.y, r1yd),
                 second_tip_x: sat(hd.x, r2x), second_tip_y: sat(hd.y, r2y),
                 degenerate: 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### design/arrow_head_tip_generator.sv
`default_nettype none
// Arrow head tip generator: takes a vector's tail and head pixels and returns the two
// barb tips of an arrow head of length HEAD_LENGTH drawn at the head, the first at +20
// degrees and the second a further -40 degrees, saturated to the screen; a vector too
// short to give a back-vector returns the head for both tips with degenerate set. One
// item enters every cycle while no stall is held; the bit-serial scaling search finds
// one result bit per stage. A stall on the tip side holds the whole pipeline.
module arrow_head_tip_generator
  import aht_pkg::*;
#(
  parameter int HEAD_LENGTH = HEAD_LENGTH_DF,
  parameter int FRAC_BITS   = FRAC_BITS_DF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic vec_valid,
  output logic      vec_stall,
  input  wire vec_t vec,
  output logic      tip_valid,
  input  wire logic tip_stall,
  output tip_t      tip
);

`include "arrow_head_tip_generator_macros.svh"

  localparam int LW = $clog2(HEAD_LENGTH + 1);
  localparam int MW = 2 * VW + 2 * LW;

  logic                 en;
  logic                 p_valid, s_valid;
  logic [SW-1:0]        s;
  logic [MW-1:0]        m2x, m2y;
  logic                 negx, negy;
  point_t               p_head, s_head;
  logic                 p_degen, s_degen;
  logic signed [LW+1:0] wx, wy;

  assign en        = !(tip_valid && tip_stall);
  assign vec_stall = !en;

  aht_prep #(.HEAD_LENGTH(HEAD_LENGTH)) u_prep (
    .clk, .rst, .en,
    .in_valid (vec_valid),
    .vec,
    .valid    (p_valid),
    .s, .m2x, .m2y, .negx, .negy,
    .head     (p_head),
    .degen    (p_degen)
  );

  aht_scale #(.HEAD_LENGTH(HEAD_LENGTH)) u_scale (
    .clk, .rst, .en,
    .in_valid (p_valid),
    .s, .m2x, .m2y, .negx, .negy,
    .head_in  (p_head),
    .degen_in (p_degen),
    .valid    (s_valid),
    .wx, .wy,
    .head     (s_head),
    .degen    (s_degen)
  );

  aht_rot #(.HEAD_LENGTH(HEAD_LENGTH), .FRAC_BITS(FRAC_BITS)) u_rot (
    .clk, .rst, .en,
    .in_valid (s_valid),
    .wx, .wy,
    .head_in  (s_head),
    .degen_in (s_degen),
    .valid    (tip_valid),
    .tip
  );

  `AHT_CHECK(a_degen_same_tips, tip_valid && tip.degenerate,
    (tip.first_tip_x == tip.second_tip_x) && (tip.first_tip_y == tip.second_tip_y),
    "degenerate item with differing tips")
  `AHT_CHECK(a_stall_back, tip_valid && tip_stall, vec_stall,
    "input taken while result stalled")
  `AHT_CHECK_RST(a_reset_empty, rst, !tip_valid,
    "result valid right after reset")

endmodule
`default_nettype wire
